// ===== rtl/cpd_pkg.sv =====
// Shared types and constants for the tape pulse decoder.
// Item structs, configuration struct, mode/kind/register codes. No dependencies.
`default_nettype none
package cpd_pkg;

    typedef struct packed {
        logic        cmd;
        logic        level;
        logic [63:0] timestamp;
    } in_item_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
        logic       last;
        logic       idle;
    } out_item_t;

    typedef struct packed {
        logic [23:0] sync_gap_min;
        logic [23:0] sync_gap_max;
        logic [23:0] bit_gap;
        logic [7:0]  zero_pulses;
        logic [7:0]  one_pulses;
    } cfg_t;

    // one or two result items produced by a single input item
    typedef struct packed {
        logic      two;
        out_item_t first;
        out_item_t second;
    } step_res_t;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] REG_SYNC_GAP_MIN = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SYNC_GAP_MAX = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BIT_GAP      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ZERO_PULSES  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ONE_PULSES   = 3'd4;

    localparam logic [1:0] MODE_IDLE = 2'd0;
    localparam logic [1:0] MODE_SYNC = 2'd1;
    localparam logic [1:0] MODE_DATA = 2'd2;
    localparam logic [1:0] MODE_END  = 2'd3;

    localparam logic [1:0] KIND_STATUS = 2'd0;
    localparam logic [1:0] KIND_BYTE   = 2'd1;
    localparam logic [1:0] KIND_EOF    = 2'd2;

    localparam logic [7:0] FIRST_BIT   = 8'h80;
    localparam logic [7:0] PULSE_MAX   = 8'hFF;

endpackage
`default_nettype wire

// ===== rtl/cpd_cfg.sv =====
// Configuration register file for the tape pulse decoder.
// Depends on cpd_pkg.
`default_nettype none
module cpd_cfg (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_we,
    input  wire logic [cpd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [cpd_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    output cpd_pkg::cfg_t                        cfg
);

    cpd_pkg::cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.sync_gap_min <= 24'd1000;
            cfg_reg.sync_gap_max <= 24'd100000;
            cfg_reg.bit_gap      <= 24'd3000;
            cfg_reg.zero_pulses  <= 8'd4;
            cfg_reg.one_pulses   <= 8'd9;
        end else if (cfg_we) begin
            unique case (cfg_index)
                cpd_pkg::REG_SYNC_GAP_MIN: cfg_reg.sync_gap_min <= cfg_wdata;
                cpd_pkg::REG_SYNC_GAP_MAX: cfg_reg.sync_gap_max <= cfg_wdata;
                cpd_pkg::REG_BIT_GAP:      cfg_reg.bit_gap      <= cfg_wdata;
                cpd_pkg::REG_ZERO_PULSES:  cfg_reg.zero_pulses  <= cfg_wdata[7:0];
                cpd_pkg::REG_ONE_PULSES:   cfg_reg.one_pulses   <= cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule
`default_nettype wire

// ===== rtl/cpd_decode.sv =====
// Decoder state and per-item step logic: gap measurement, mode machine,
// pulse counting and bit assembly. Depends on cpd_pkg.
`default_nettype none
module cpd_decode (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              step,
    input  wire cpd_pkg::in_item_t item,
    input  wire cpd_pkg::cfg_t     cfg,
    output cpd_pkg::step_res_t     res
);

    logic [1:0]  mode_reg, mode_next;
    logic [63:0] last_time_reg, last_time_next;
    logic [7:0]  bit_mask_reg, bit_mask_next;
    logic [7:0]  pulse_count_reg, pulse_count_next;
    logic [7:0]  shift_byte_reg, shift_byte_next;
    logic        last_level_reg, last_level_next;

    logic [63:0] gap;
    logic        gap_hi;
    logic        gt_min, lt_min, lt_max, lt_bit;
    logic        is_zero, is_one;
    logic [7:0]  merged;
    logic [7:0]  mask_shr;
    logic        emit_byte, emit_eof;
    logic [7:0]  byte_val;
    logic        idle_after;

    assign gap     = item.timestamp - last_time_reg;
    assign gap_hi  = |gap[63:24];
    assign gt_min  = gap_hi || (gap[23:0] > cfg.sync_gap_min);
    assign lt_min  = !gap_hi && (gap[23:0] < cfg.sync_gap_min);
    assign lt_max  = !gap_hi && (gap[23:0] < cfg.sync_gap_max);
    assign lt_bit  = !gap_hi && (gap[23:0] < cfg.bit_gap);
    assign is_zero = (pulse_count_reg == cfg.zero_pulses);
    assign is_one  = (pulse_count_reg == cfg.one_pulses);
    assign merged  = is_zero ? shift_byte_reg : (shift_byte_reg | bit_mask_reg);
    assign mask_shr = bit_mask_reg >> 1;

    always_comb begin
        mode_next        = mode_reg;
        last_time_next   = last_time_reg;
        bit_mask_next    = bit_mask_reg;
        pulse_count_next = pulse_count_reg;
        shift_byte_next  = shift_byte_reg;
        last_level_next  = last_level_reg;
        emit_byte        = 1'b0;
        emit_eof         = 1'b0;
        byte_val         = 8'h00;

        if (item.cmd) begin
            mode_next = cpd_pkg::MODE_IDLE;
        end else begin
            last_time_next = item.timestamp;
            unique case (mode_reg)
                cpd_pkg::MODE_IDLE: begin
                    if (!item.level && gt_min && lt_max) begin
                        mode_next = cpd_pkg::MODE_SYNC;
                    end
                end
                cpd_pkg::MODE_SYNC: begin
                    if (lt_min) begin
                        mode_next = cpd_pkg::MODE_END;
                    end else if (item.level) begin
                        bit_mask_next    = cpd_pkg::FIRST_BIT;
                        pulse_count_next = 8'd0;
                        shift_byte_next  = 8'd0;
                        last_level_next  = 1'b1;
                        mode_next        = cpd_pkg::MODE_DATA;
                    end
                end
                cpd_pkg::MODE_DATA: begin
                    if (item.level == last_level_reg) begin
                        // repeated level: flush a byte missing only its last bit
                        if (bit_mask_reg == 8'd1) begin
                            byte_val        = shift_byte_reg | {7'd0, !is_zero};
                            shift_byte_next = byte_val;
                            emit_byte       = 1'b1;
                        end
                        emit_eof  = 1'b1;
                        mode_next = cpd_pkg::MODE_END;
                    end else begin
                        last_level_next = item.level;
                        if (lt_bit) begin
                            if (!item.level && pulse_count_reg != cpd_pkg::PULSE_MAX) begin
                                pulse_count_next = pulse_count_reg + 8'd1;
                            end
                        end else if (!is_zero && !is_one) begin
                            emit_eof  = 1'b1;
                            mode_next = cpd_pkg::MODE_END;
                        end else begin
                            pulse_count_next = 8'd0;
                            if (mask_shr == 8'd0) begin
                                emit_byte       = 1'b1;
                                byte_val        = merged;
                                bit_mask_next   = cpd_pkg::FIRST_BIT;
                                shift_byte_next = 8'd0;
                            end else begin
                                bit_mask_next   = mask_shr;
                                shift_byte_next = merged;
                            end
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    assign idle_after = (mode_next == cpd_pkg::MODE_IDLE) || (mode_next == cpd_pkg::MODE_END);

    always_comb begin
        res.two         = emit_byte && emit_eof;
        res.first.idle  = idle_after;
        res.second.idle = idle_after;
        res.second.kind = cpd_pkg::KIND_EOF;
        res.second.data = 8'h00;
        res.second.last = 1'b1;
        if (emit_byte) begin
            res.first.kind = cpd_pkg::KIND_BYTE;
            res.first.data = byte_val;
            res.first.last = !emit_eof;
        end else if (emit_eof) begin
            res.first.kind = cpd_pkg::KIND_EOF;
            res.first.data = 8'h00;
            res.first.last = 1'b1;
        end else begin
            res.first.kind = cpd_pkg::KIND_STATUS;
            res.first.data = 8'h00;
            res.first.last = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg        <= cpd_pkg::MODE_IDLE;
            last_time_reg   <= 64'd0;
            bit_mask_reg    <= 8'd0;
            pulse_count_reg <= 8'd0;
            shift_byte_reg  <= 8'd0;
            last_level_reg  <= 1'b0;
        end else if (step) begin
            mode_reg        <= mode_next;
            last_time_reg   <= last_time_next;
            bit_mask_reg    <= bit_mask_next;
            pulse_count_reg <= pulse_count_next;
            shift_byte_reg  <= shift_byte_next;
            last_level_reg  <= last_level_next;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/cpd_outbuf.sv =====
// Result buffer: holds the one or two result items of a step and
// presents them in order on the result channel. Depends on cpd_pkg.
`default_nettype none
module cpd_outbuf (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               load,
    input  wire cpd_pkg::step_res_t res,
    output logic                    can_load,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output cpd_pkg::out_item_t      m_item
);

    logic [1:0]         cnt_reg;
    cpd_pkg::out_item_t head_reg;
    cpd_pkg::out_item_t tail_reg;

    assign m_valid  = (cnt_reg != 2'd0);
    assign m_item   = head_reg;
    assign can_load = (cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
        end else if (load) begin
            cnt_reg <= res.two ? 2'd2 : 2'd1;
        end else if (m_valid && m_ready) begin
            cnt_reg <= cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            head_reg <= res.first;
            tail_reg <= res.second;
        end else if (m_valid && m_ready) begin
            head_reg <= tail_reg;
        end
    end

    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg != 2'd3) else $error("result count out of range");

    a_load_gated: assert property (@(posedge aclk) disable iff (!aresetn)
        load |-> can_load) else $error("step loaded while buffer busy");

    // a result that is not the last of its item always has its partner queued
    a_pair_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_item.last) |-> (cnt_reg == 2'd2))
        else $error("non-final result without a follower");

    a_pair_tail: assert property (@(posedge aclk) disable iff (!aresetn)
        (load && res.two) |=> (!head_reg.last && tail_reg.last))
        else $error("two-result step loaded with wrong last flags");

endmodule
`default_nettype wire

// ===== rtl/cassette_pulse_decoder.sv =====
// Tape pulse decoder top level: input register, decoder step, result buffer.
// An accepted input item is held in the input register, then its results go to the result buffer that drives m_.
// Throughput: one input item per cycle for single-result items while m_ready is high; an item that
// yields a byte and end of file holds the result buffer until both results are taken.
// Reset (aresetn low, synchronous): registers to defaults, mode idle, buffers empty.
// Depends on cpd_pkg, cpd_cfg, cpd_decode, cpd_outbuf.
`default_nettype none
module cassette_pulse_decoder (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_we,
    input  wire logic [cpd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [cpd_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire cpd_pkg::in_item_t              s_item,
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output cpd_pkg::out_item_t                  m_item
);

    cpd_pkg::cfg_t      cfg;
    cpd_pkg::in_item_t  in_reg;
    logic               in_valid_reg;
    cpd_pkg::step_res_t res;
    logic               can_load;
    logic               step;

    assign step    = in_valid_reg && can_load;
    assign s_ready = !in_valid_reg || can_load;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg <= s_item;
        end
    end

    cpd_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    cpd_decode u_decode (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .item    (in_reg),
        .cfg     (cfg),
        .res     (res)
    );

    cpd_outbuf u_outbuf (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (step),
        .res      (res),
        .can_load (can_load),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_item   (m_item)
    );

endmodule
`default_nettype wire

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for cassette_pulse_decoder: random and directed tape events.
// A clocked driver and monitor around the DUT, checked against a built-in decoder model.
// Depends on cpd_pkg and the cassette_pulse_decoder RTL.
module tb;
    import cpd_pkg::*;

    localparam int unsigned LIMIT = 400000;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    in_item_t              s_item = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    out_item_t             m_item;

    cassette_pulse_decoder dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    in_item_t    events_q[$];
    out_item_t   results_q[$];
    int unsigned errors = 0;
    int unsigned cycles = 0;
    int unsigned made = 0;
    bit          s_fire = 1'b0;
    bit          calm = 1'b0;
    bit          hold_req = 1'b0;
    bit          hold_done = 1'b0;
    int unsigned stall_left = 0;

    // decoder model state and register copy
    cfg_t        regs = '{sync_gap_min: 24'd1000, sync_gap_max: 24'd100000,
                          bit_gap: 24'd3000, zero_pulses: 8'd4, one_pulses: 8'd9};
    logic [1:0]  dec_mode = MODE_IDLE;
    logic [63:0] dec_time = '0;
    logic [7:0]  dec_mask = '0;
    logic [7:0]  dec_pulses = '0;
    logic [7:0]  dec_byte = '0;
    logic        dec_level = 1'b0;

    // stimulus generator's view of the line
    logic [63:0] gen_t = '0;
    logic        gen_lvl = 1'b0;

    function automatic out_item_t result(input logic [1:0] kind, input logic [7:0] data);
        out_item_t r;
        r.kind = kind;
        r.data = data;
        r.last = 1'b0;
        r.idle = 1'b0;
        return r;
    endfunction

    function automatic string show(input out_item_t r);
        return $sformatf("kind=%0d data=%02h last=%0b idle=%0b",
                         r.kind, r.data, r.last, r.idle);
    endfunction

    task automatic decode_event(input in_item_t ev);
        out_item_t   outs[$];
        logic [63:0] gap;
        logic        idl;
        out_item_t   r;
        if (ev.cmd) begin
            dec_mode = MODE_IDLE;
        end else begin
            gap = ev.timestamp - dec_time;
            dec_time = ev.timestamp;
            case (dec_mode)
                MODE_IDLE: begin
                    if (!ev.level && gap > regs.sync_gap_min && gap < regs.sync_gap_max)
                        dec_mode = MODE_SYNC;
                end
                MODE_SYNC: begin
                    if (gap < regs.sync_gap_min) begin
                        dec_mode = MODE_END;
                    end else if (ev.level) begin
                        dec_mask = FIRST_BIT;
                        dec_pulses = '0;
                        dec_byte = '0;
                        dec_level = 1'b1;
                        dec_mode = MODE_DATA;
                    end
                end
                MODE_DATA: begin
                    if (ev.level == dec_level) begin
                        // repeated level: flush a byte that lacks only its last bit
                        if (dec_mask == 8'd1) begin
                            if (dec_pulses != regs.zero_pulses)
                                dec_byte[0] = 1'b1;
                            outs.insert(outs.size(), result(KIND_BYTE, dec_byte));
                        end
                        outs.insert(outs.size(), result(KIND_EOF, 8'd0));
                        dec_mode = MODE_END;
                    end else begin
                        dec_level = ev.level;
                        if (gap < regs.bit_gap) begin
                            if (!ev.level && dec_pulses != PULSE_MAX)
                                dec_pulses = dec_pulses + 8'd1;
                        end else if (dec_pulses != regs.zero_pulses &&
                                     dec_pulses != regs.one_pulses) begin
                            outs.insert(outs.size(), result(KIND_EOF, 8'd0));
                            dec_mode = MODE_END;
                        end else begin
                            if (dec_pulses != regs.zero_pulses)
                                dec_byte = dec_byte | dec_mask;
                            dec_pulses = '0;
                            dec_mask = dec_mask >> 1;
                            if (dec_mask == 8'd0) begin
                                outs.insert(outs.size(), result(KIND_BYTE, dec_byte));
                                dec_mask = FIRST_BIT;
                                dec_byte = '0;
                            end
                        end
                    end
                end
                default: ;
            endcase
        end
        if (outs.size() == 0)
            outs.insert(0, result(KIND_STATUS, 8'd0));
        idl = (dec_mode == MODE_IDLE || dec_mode == MODE_END);
        for (int k = 0; k < outs.size(); k++) begin
            r = outs[k];
            r.idle = idl;
            r.last = (k == outs.size() - 1);
            results_q.insert(results_q.size(), r);
        end
    endtask

    // monitor: input acceptance feeds the model, results are checked in order
    always @(posedge aclk) begin : monitor
        out_item_t want;
        s_fire = aresetn && s_valid && s_ready;
        if (s_fire)
            decode_event(s_item);
        if (aresetn && m_valid && m_ready) begin
            if (results_q.size() == 0) begin
                $display("%0t: unexpected result: expected none, actual %s",
                         $time, show(m_item));
                errors++;
            end else begin
                want = results_q.pop_front();
                if (m_item.kind !== want.kind || m_item.data !== want.data ||
                    m_item.last !== want.last || m_item.idle !== want.idle) begin
                    $display("%0t: mismatch: expected %s, actual %s",
                             $time, show(want), show(m_item));
                    errors++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("FAIL cassette_pulse_decoder");
            $finish;
        end
    end

    // sender
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_fire) begin
            if (events_q.size() != 0 && (calm || $urandom_range(99, 0) >= 34)) begin
                s_item <= events_q.pop_front();
                s_valid <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // receiver, with one long hold-off on request
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            m_ready <= 1'b0;
        end else if (hold_req && !hold_done) begin
            stall_left <= 300;
            hold_done <= 1'b1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= calm || ($urandom_range(99, 0) >= 34);
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val[CFG_DATA_W-1:0];
        @(negedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            REG_SYNC_GAP_MIN: regs.sync_gap_min = val[23:0];
            REG_SYNC_GAP_MAX: regs.sync_gap_max = val[23:0];
            REG_BIT_GAP:      regs.bit_gap = val[23:0];
            REG_ZERO_PULSES:  regs.zero_pulses = val[7:0];
            REG_ONE_PULSES:   regs.one_pulses = val[7:0];
            default: ;
        endcase
    endtask

    task automatic set_cfg(input int unsigned smin, input int unsigned smax,
                           input int unsigned bgap, input int unsigned zero,
                           input int unsigned one);
        write_reg(REG_SYNC_GAP_MIN, smin);
        write_reg(REG_SYNC_GAP_MAX, smax);
        write_reg(REG_BIT_GAP, bgap);
        write_reg(REG_ZERO_PULSES, zero);
        write_reg(REG_ONE_PULSES, one);
    endtask

    // all items accepted and all results seen, then let the pipeline settle
    task automatic drain();
        while (events_q.size() != 0 || s_valid || results_q.size() != 0)
            @(negedge aclk);
        repeat (8) @(negedge aclk);
    endtask

    function automatic logic [63:0] span(input int unsigned lo, input int unsigned hi);
        return (lo > hi) ? 64'(lo) : 64'($urandom_range(hi, lo));
    endfunction

    function automatic logic [63:0] small_gap();
        return (regs.bit_gap == 0) ? 64'd0 : span(0, regs.bit_gap - 1);
    endfunction

    task automatic queue_event(input logic cmd, input logic lvl, input logic [63:0] gap);
        in_item_t ev;
        ev.cmd = cmd;
        ev.level = lvl;
        if (cmd) begin
            // timestamp of a restart is don't-care, use it to toggle bits
            ev.timestamp = {$urandom, $urandom};
        end else begin
            gen_t = gen_t + gap;
            gen_lvl = lvl;
            ev.timestamp = gen_t;
        end
        events_q.insert(events_q.size(), ev);
        made++;
    endtask

    task automatic noise();
        logic [63:0] gap;
        case ($urandom_range(3, 0))
            0: gap = span(0, 3000);
            1: gap = span(0, 200000);
            2: gap = {$urandom, $urandom};
            default: gap = '0;
        endcase
        queue_event($urandom_range(9, 0) == 0, 1'($urandom_range(1, 0)), gap);
    endtask

    // pulses of one bit; the finishing edge carries the long gap
    task automatic send_bit(input int unsigned cnt, input bit finish);
        int unsigned lows;
        lows = 0;
        while (lows < cnt) begin
            queue_event(1'b0, !gen_lvl, small_gap());
            if (!gen_lvl)
                lows++;
        end
        if (finish)
            queue_event(1'b0, !gen_lvl, span(regs.bit_gap, regs.bit_gap + 200));
    endtask

    function automatic int unsigned rand_count();
        return $urandom_range(1, 0) ? regs.one_pulses : regs.zero_pulses;
    endfunction

    // restart, sync window, optional extra sync lows, then the data start edge or a too-short gap
    task automatic enter_data(output bit ok);
        queue_event(1'b1, 1'b0, '0);
        queue_event(1'b0, 1'b0, span(regs.sync_gap_min + 1, regs.sync_gap_max - 1));
        repeat ($urandom_range(2, 0))
            queue_event(1'b0, 1'b0, span(regs.sync_gap_min, regs.sync_gap_min + 300));
        ok = 1'b1;
        if (regs.sync_gap_min != 0 && $urandom_range(11, 0) == 0) begin
            queue_event(1'b0, 1'($urandom_range(1, 0)), span(0, regs.sync_gap_min - 1));
            ok = 1'b0;
        end else begin
            queue_event(1'b0, 1'b1, span(regs.sync_gap_min, regs.sync_gap_min + 300));
        end
    endtask

    task automatic frame();
        bit          ok;
        int unsigned c;
        int unsigned tries;
        enter_data(ok);
        if (ok) begin
            repeat ($urandom_range(2, 0))
                repeat (8) send_bit(rand_count(), 1'b1);
            case ($urandom_range(4, 0))
                0: queue_event(1'b0, gen_lvl, span(0, 5000));
                1: begin
                    repeat (7) send_bit(rand_count(), 1'b1);
                    c = $urandom_range(1, 0) ? rand_count() : $urandom_range(12, 0);
                    send_bit(c, 1'b0);
                    queue_event(1'b0, gen_lvl, span(0, 5000));
                end
                2: begin
                    c = $urandom_range(12, 0);
                    tries = 0;
                    while ((c == regs.zero_pulses || c == regs.one_pulses) && tries < 20) begin
                        c = $urandom_range(12, 0);
                        tries++;
                    end
                    send_bit(c, 1'b1);
                end
                3: queue_event(1'b1, 1'b0, '0);
                default: ;
            endcase
        end
        // events after the session ends are ignored until a restart
        repeat ($urandom_range(2, 0))
            queue_event(1'b0, 1'($urandom_range(1, 0)), span(0, 5000));
    endtask

    task automatic run_phase(input int unsigned target);
        made = 0;
        while (made < target) begin
            if ($urandom_range(99, 0) < 80)
                frame();
            else
                noise();
        end
    endtask

    initial begin : stimulus
        bit ok;
        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;

        // directed: timestamp wrap, sync window edges, short sync gap, end mode
        queue_event(1'b0, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF);
        queue_event(1'b0, 1'b0, 64'd1);
        queue_event(1'b0, 1'b0, 64'd1001);
        queue_event(1'b0, 1'b0, 64'd1000);
        queue_event(1'b0, 1'b1, 64'd999);
        queue_event(1'b0, 1'b0, 64'd5);
        queue_event(1'b1, 1'b1, '0);
        queue_event(1'b0, 1'b0, 64'd1000);
        queue_event(1'b0, 1'b0, 64'd100000);
        queue_event(1'b0, 1'b0, 64'd99999);
        queue_event(1'b0, 1'b1, 64'd1000);
        queue_event(1'b0, 1'b1, 64'd10);
        queue_event(1'b1, 1'b0, '0);
        queue_event(1'b0, 1'b0, 64'd1000);
        queue_event(1'b0, 1'b1, 64'd2000);
        queue_event(1'b0, 1'b1, 64'd0);
        run_phase(300);
        drain();

        set_cfg(0, 24'hFFFFFF, 1, 0, 1);
        run_phase(250);
        drain();

        // equal pulse counts, narrowest sync window, no idling anywhere
        calm = 1'b1;
        set_cfg(24'hFFFFFD, 24'hFFFFFF, 24'hFFFFFF, 5, 5);
        run_phase(200);
        drain();
        calm = 1'b0;

        // pulse counter saturation decodes as a one bit
        set_cfg(100, 5000, 300, 3, 255);
        enter_data(ok);
        if (ok) begin
            send_bit(260, 1'b1);
            repeat (7) send_bit(regs.zero_pulses, 1'b1);
            queue_event(1'b0, gen_lvl, 64'd50);
        end
        drain();

        repeat (3) begin
            set_cfg($urandom_range(2000, 0), 0, 0, $urandom_range(10, 0),
                    $urandom_range(10, 0));
            write_reg(REG_SYNC_GAP_MAX, regs.sync_gap_min + $urandom_range(60000, 2));
            write_reg(REG_BIT_GAP, ($urandom_range(9, 0) == 0) ? 0 : $urandom_range(4000, 1));
            run_phase(250);
            hold_req = 1'b1;
            drain();
        end

        set_cfg(0, 0, 0, 0, 0);
        repeat (40) noise();
        drain();

        if (errors == 0)
            $display("PASS cassette_pulse_decoder");
        else
            $display("FAIL cassette_pulse_decoder");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/cpd_pkg.sv
rtl/cpd_cfg.sv
rtl/cpd_decode.sv
rtl/cpd_outbuf.sv
rtl/cassette_pulse_decoder.sv
tb/sv/tb.sv
